/* hw/rtl/ssi_pkg.sv */
// Shared package of the segment-sphere intersection unit.
// Holds the configuration register constants and the queue status type.
// No dependencies.
package ssi_pkg;

   // Squared-length floor register
   localparam int MIN_LEN_WIDTH = 31;
   localparam logic [MIN_LEN_WIDTH-1:0] MIN_LEN_RESET = 31'd328;

   // Queue occupancy flags seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* hw/rtl/segment_sphere_intersect_unit.sv */
// Segment-sphere intersection unit, top level. Depends on ssi_pkg, ssi_front,
// ssi_queue and ssi_back.
// From request to result, a request passes the front stages, the queue, the
//   square-root stages (one root bit each) and the divider stages.
// Throughput: one request per cycle unless stalled; each part stalls alone.
// Reset: synchronous; empties all stages and the queue, floor register = 328.
module segment_sphere_intersect_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COORD_WIDTH-1:0]          req_start_x,
   input  logic signed [COORD_WIDTH-1:0]          req_start_y,
   input  logic signed [COORD_WIDTH-1:0]          req_start_z,
   input  logic signed [COORD_WIDTH-1:0]          req_end_x,
   input  logic signed [COORD_WIDTH-1:0]          req_end_y,
   input  logic signed [COORD_WIDTH-1:0]          req_end_z,
   input  logic signed [COORD_WIDTH-1:0]          req_center_x,
   input  logic signed [COORD_WIDTH-1:0]          req_center_y,
   input  logic signed [COORD_WIDTH-1:0]          req_center_z,
   input  logic        [COORD_WIDTH-2:0]          req_sphere_radius,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic signed [COORD_WIDTH-1:0]          rsp_point_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_point_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_point_z,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ssi_pkg::MIN_LEN_WIDTH-1:0]      csr_min_length_sq
);

   localparam int EW = 4 * (2 * COORD_WIDTH + 2) + 6 * COORD_WIDTH + 4;

   logic [ssi_pkg::MIN_LEN_WIDTH-1:0] min_len_ff;
   ssi_pkg::qstat_type                qstat;
   logic                              push, pop;
   logic [EW-1:0]                     push_data, head_data;

   // Floor register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= ssi_pkg::MIN_LEN_RESET;
      end else if (csr_valid) begin
         min_len_ff <= csr_min_length_sq;
      end
   end

   ssi_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_start_z       (req_start_z),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_end_z         (req_end_z),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_center_z      (req_center_z),
      .req_sphere_radius (req_sphere_radius),
      .min_len           (min_len_ff),
      .qstat             (qstat),
      .push              (push),
      .push_data         (push_data)
   );

   ssi_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .qstat     (qstat)
   );

   ssi_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_hit     (rsp_hit),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_point_z (rsp_point_z)
   );

endmodule

/* hw/rtl/ssi_front.sv */
// Front part of the segment-sphere unit: takes requests, forms a, h, c,
// classifies hit or miss and forms the discriminant. Depends on ssi_pkg.
module ssi_front #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COORD_WIDTH-1:0]          req_start_x,
   input  logic signed [COORD_WIDTH-1:0]          req_start_y,
   input  logic signed [COORD_WIDTH-1:0]          req_start_z,
   input  logic signed [COORD_WIDTH-1:0]          req_end_x,
   input  logic signed [COORD_WIDTH-1:0]          req_end_y,
   input  logic signed [COORD_WIDTH-1:0]          req_end_z,
   input  logic signed [COORD_WIDTH-1:0]          req_center_x,
   input  logic signed [COORD_WIDTH-1:0]          req_center_y,
   input  logic signed [COORD_WIDTH-1:0]          req_center_z,
   input  logic        [COORD_WIDTH-2:0]          req_sphere_radius,
   input  logic        [ssi_pkg::MIN_LEN_WIDTH-1:0] min_len,
   input  ssi_pkg::qstat_type                     qstat,
   output logic                                   push,
   output logic [4*(2*COORD_WIDTH+2)+6*COORD_WIDTH+3:0] push_data
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int HW  = DW;
   localparam int SW  = PW + 1;
   localparam int TW  = PW + 3;
   localparam int DPW = 2 * PW;
   localparam int RRW = 2 * (CW - 1);
   localparam int FLW = ssi_pkg::MIN_LEN_WIDTH + FRAC_BITS;
   localparam int LW  = (PW > FLW) ? PW : FLW;

   typedef struct packed {
      logic [2:0]         neg;
      logic [2:0][CW-1:0] mag;
      logic [2:0][CW-1:0] s;
   } geo_type;

   typedef struct packed {
      logic          hit;
      logic [PW-1:0] nh;
      logic [PW-1:0] a;
      geo_type       geo;
   } carry_type;

   typedef struct packed {
      carry_type      carry;
      logic [DPW-1:0] disc;
   } entry_type;

   logic signed [CW-1:0] st [3];
   logic signed [CW-1:0] en [3];
   logic signed [CW-1:0] ce [3];
   logic                 front_en;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   logic signed [DW-1:0] d1_ff [3];
   logic signed [DW-1:0] f1_ff [3];
   logic        [CW-1:0] s1_ff [3];
   logic        [CW-2:0] r1_ff;
   logic signed [DW-1:0] d_in  [3];
   logic signed [DW-1:0] f_in  [3];

   logic signed [PW-1:0] dd2_ff [3];
   logic signed [PW-1:0] df2_ff [3];
   logic signed [PW-1:0] ff2_ff [3];
   logic [RRW-1:0]       rr2_ff;
   geo_type              geo2_ff, geo2_in;

   logic [PW-1:0]        a3_ff;
   logic signed [SW-1:0] h3_ff, c3_ff;
   geo_type              geo3_ff;

   logic                 len4_ff, c4_ff, h4_ff;
   logic signed [TW-1:0] ah4_ff, hc4_ff;
   logic [PW-1:0]        hm4_ff, cu4_ff, a4_ff;
   logic signed [SW-1:0] hneg4_in;
   geo_type              geo4_ff;

   logic                 ok5_ff;
   logic [PW-1:0]        hll5_ff, hlh5_ff, hhh5_ff;
   logic [PW-1:0]        all5_ff, alh5_ff, ahl5_ff, ahh5_ff;
   logic [PW-1:0]        hm5_ff, a5_ff;
   logic signed [TW-1:0] far5_in;
   geo_type              geo5_ff;

   logic                 ok6_ff;
   logic [DPW-1:0]       hsq6_ff, acp6_ff;
   logic [PW-1:0]        hm6_ff, a6_ff;
   geo_type              geo6_ff;

   entry_type            entry7_ff, entry7_in;

   assign st = '{req_start_x, req_start_y, req_start_z};
   assign en = '{req_end_x, req_end_y, req_end_z};
   assign ce = '{req_center_x, req_center_y, req_center_z};

   // Stall the whole front only when its last stage cannot drain
   assign front_en  = !(v7_ff && qstat.full);
   assign req_ready = front_en;
   assign push      = v7_ff && front_en;
   assign push_data = entry7_ff;

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (front_en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Direction and start-to-centre offset
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = {en[k][CW-1], en[k]} - {st[k][CW-1], st[k]};
         f_in[k] = {st[k][CW-1], st[k]} - {ce[k][CW-1], ce[k]};
      end
   end

   // Direction magnitude and sign for the back part
   always_comb begin
      geo2_in = '0;
      for (int k = 0; k < 3; k++) begin
         geo2_in.neg[k] = d1_ff[k][DW-1];
         geo2_in.mag[k] = d1_ff[k][DW-1] ? CW'(-d1_ff[k]) : CW'(d1_ff[k]);
         geo2_in.s[k]   = s1_ff[k];
      end
   end

   // Near-root flags
   assign hneg4_in = -h3_ff;
   assign far5_in  = ah4_ff + hc4_ff;

   // Discriminant and final classification
   always_comb begin
      entry7_in           = '0;
      entry7_in.carry.hit = ok6_ff && (hsq6_ff >= acp6_ff);
      entry7_in.carry.nh  = hm6_ff;
      entry7_in.carry.a   = a6_ff;
      entry7_in.carry.geo = geo6_ff;
      entry7_in.disc      = hsq6_ff - acp6_ff;
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (front_en) begin
         // inputs
         for (int k = 0; k < 3; k++) begin
            d1_ff[k] <= d_in[k];
            f1_ff[k] <= f_in[k];
            s1_ff[k] <= st[k];
         end
         r1_ff <= req_sphere_radius;
         // products
         for (int k = 0; k < 3; k++) begin
            dd2_ff[k] <= PW'(d1_ff[k]) * PW'(d1_ff[k]);
            df2_ff[k] <= PW'(d1_ff[k]) * PW'(f1_ff[k]);
            ff2_ff[k] <= PW'(f1_ff[k]) * PW'(f1_ff[k]);
         end
         rr2_ff  <= RRW'(r1_ff) * RRW'(r1_ff);
         geo2_ff <= geo2_in;
         // quadratic terms
         a3_ff   <= PW'(dd2_ff[0]) + PW'(dd2_ff[1]) + PW'(dd2_ff[2]);
         h3_ff   <= SW'(df2_ff[0]) + SW'(df2_ff[1]) + SW'(df2_ff[2]);
         c3_ff   <= SW'(ff2_ff[0]) + SW'(ff2_ff[1]) + SW'(ff2_ff[2])
                    - $signed(SW'(rr2_ff));
         geo3_ff <= geo2_ff;
         // range checks
         len4_ff <= (a3_ff != '0)
                    && (LW'(a3_ff) >= (LW'(min_len) << FRAC_BITS));
         c4_ff   <= !c3_ff[SW-1];
         h4_ff   <= h3_ff[SW-1] || (h3_ff == '0);
         ah4_ff  <= TW'(a3_ff) + TW'(h3_ff);
         hc4_ff  <= TW'(h3_ff) + TW'(c3_ff);
         hm4_ff  <= hneg4_in[PW-1:0];
         cu4_ff  <= c3_ff[PW-1:0];
         a4_ff   <= a3_ff;
         geo4_ff <= geo3_ff;
         // partial products of h*h and a*c
         ok5_ff  <= len4_ff && c4_ff && h4_ff
                    && !(ah4_ff[TW-1] && !far5_in[TW-1] && (far5_in != '0));
         hll5_ff <= PW'(hm4_ff[HW-1:0]) * PW'(hm4_ff[HW-1:0]);
         hlh5_ff <= PW'(hm4_ff[HW-1:0]) * PW'(hm4_ff[PW-1:HW]);
         hhh5_ff <= PW'(hm4_ff[PW-1:HW]) * PW'(hm4_ff[PW-1:HW]);
         all5_ff <= PW'(a4_ff[HW-1:0]) * PW'(cu4_ff[HW-1:0]);
         alh5_ff <= PW'(a4_ff[HW-1:0]) * PW'(cu4_ff[PW-1:HW]);
         ahl5_ff <= PW'(a4_ff[PW-1:HW]) * PW'(cu4_ff[HW-1:0]);
         ahh5_ff <= PW'(a4_ff[PW-1:HW]) * PW'(cu4_ff[PW-1:HW]);
         hm5_ff  <= hm4_ff;
         a5_ff   <= a4_ff;
         geo5_ff <= geo4_ff;
         // full products
         ok6_ff  <= ok5_ff;
         hsq6_ff <= (DPW'(hhh5_ff) << PW) + (DPW'(hlh5_ff) << (HW + 1))
                    + DPW'(hll5_ff);
         acp6_ff <= (DPW'(ahh5_ff) << PW)
                    + ((DPW'(alh5_ff) + DPW'(ahl5_ff)) << HW) + DPW'(all5_ff);
         hm6_ff  <= hm5_ff;
         a6_ff   <= a5_ff;
         geo6_ff <= geo5_ff;
         // queue entry
         entry7_ff <= entry7_in;
      end
   end

endmodule

/* hw/rtl/ssi_queue.sv */
// Short queue between the front and back parts of the segment-sphere unit.
// Depends on ssi_pkg for the status flags.
module ssi_queue #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   push_data,
   input  logic               pop,
   output logic [WIDTH-1:0]   head_data,
   output ssi_pkg::qstat_type qstat
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTRW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign qstat.full  = (count_ff == CNTW'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_data   = store_ff[rd_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/ssi_back.sv */
// Back part of the segment-sphere unit: square root of the discriminant,
// scaling of the direction and the result register. Depends on ssi_pkg.
module ssi_back #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ssi_pkg::qstat_type                     qstat,
   input  logic [4*(2*COORD_WIDTH+2)+6*COORD_WIDTH+3:0] head_data,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic signed [COORD_WIDTH-1:0]          rsp_point_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_point_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_point_z
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int DPW = 2 * PW;
   localparam int RW  = PW + 4;
   localparam int PRW = PW + CW;

   typedef struct packed {
      logic [2:0]         neg;
      logic [2:0][CW-1:0] mag;
      logic [2:0][CW-1:0] s;
   } geo_type;

   typedef struct packed {
      logic          hit;
      logic [PW-1:0] nh;
      logic [PW-1:0] a;
      geo_type       geo;
   } carry_type;

   typedef struct packed {
      carry_type      carry;
      logic [DPW-1:0] disc;
   } entry_type;

   entry_type       head;
   logic            back_en;

   // square root stages
   logic            sv_ff    [PW+1];
   carry_type       sc_ff    [PW+1];
   logic [DPW-1:0]  srad_ff  [PW+1];
   logic [RW-1:0]   srem_ff  [PW+1];
   logic [PW-1:0]   sroot_ff [PW+1];

   // numerator and products
   logic            nv_ff, mv_ff;
   carry_type       nc_ff, mc_ff;
   logic [PW-1:0]   num_ff;
   logic [2*CW-1:0] plo_ff [3];
   logic [PW-1:0]   phi_ff [3];
   logic [PRW-1:0]  prod_in [3];

   // division stages
   logic            dv_ff   [CW+1];
   carry_type       dc_ff   [CW+1];
   logic [PW-1:0]   drem_ff [CW+1][3];
   logic [CW-1:0]   dlow_ff [CW+1][3];
   logic [CW-1:0]   dq_ff   [CW+1][3];

   // result
   logic            rsp_valid_ff;
   logic            rsp_hit_ff;
   logic [CW-1:0]   point_ff [3];
   logic [CW-1:0]   point_in [3];

   assign head      = head_data;
   assign back_en   = !rsp_valid_ff || rsp_ready;
   assign pop       = back_en && !qstat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_point_x = point_ff[0];
   assign rsp_point_y = point_ff[1];
   assign rsp_point_z = point_ff[2];

   // Load the request at the queue head
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (back_en) begin
         sv_ff[0] <= !qstat.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         sc_ff[0]    <= head.carry;
         srad_ff[0]  <= head.disc;
         srem_ff[0]  <= '0;
         sroot_ff[0] <= '0;
      end
   end

   // One root bit per stage
   for (genvar i = 0; i < PW; i++) begin : g_sqrt
      logic [RW-1:0] cur;
      logic [RW-1:0] sub;
      logic          ge;

      assign cur = {srem_ff[i][RW-3:0], srad_ff[i][DPW-1:DPW-2]};
      assign sub = RW'({sroot_ff[i], 2'b01});
      assign ge  = (cur >= sub);

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[i+1] <= 1'b0;
         end else if (back_en) begin
            sv_ff[i+1] <= sv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (back_en) begin
            sc_ff[i+1]    <= sc_ff[i];
            srad_ff[i+1]  <= srad_ff[i] << 2;
            srem_ff[i+1]  <= ge ? cur - sub : cur;
            sroot_ff[i+1] <= {sroot_ff[i][PW-2:0], ge};
         end
      end
   end

   // Numerator, then its products with the direction magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
         mv_ff <= 1'b0;
      end else if (back_en) begin
         nv_ff <= sv_ff[PW];
         mv_ff <= nv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         nc_ff  <= sc_ff[PW];
         num_ff <= sc_ff[PW].nh - sroot_ff[PW];
         mc_ff  <= nc_ff;
         for (int k = 0; k < 3; k++) begin
            plo_ff[k] <= (2*CW)'(num_ff[CW-1:0]) * (2*CW)'(nc_ff.geo.mag[k]);
            phi_ff[k] <= PW'(num_ff[PW-1:CW]) * PW'(nc_ff.geo.mag[k]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = PRW'(plo_ff[k]) + (PRW'(phi_ff[k]) << CW);
      end
   end

   // Seed the dividers with the upper product bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (back_en) begin
         dv_ff[0] <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         dc_ff[0] <= mc_ff;
         for (int k = 0; k < 3; k++) begin
            drem_ff[0][k] <= prod_in[k][PRW-1:CW];
            dlow_ff[0][k] <= prod_in[k][CW-1:0];
            dq_ff[0][k]   <= '0;
         end
      end
   end

   // One quotient bit per stage in each lane
   for (genvar j = 0; j < CW; j++) begin : g_div
      logic [PW:0] cur [3];
      logic [PW:0] den;
      logic        ge  [3];

      assign den = {1'b0, dc_ff[j].a};

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            cur[k] = {drem_ff[j][k], dlow_ff[j][k][CW-1]};
            ge[k]  = (cur[k] >= den);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (back_en) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (back_en) begin
            dc_ff[j+1] <= dc_ff[j];
            for (int k = 0; k < 3; k++) begin
               drem_ff[j+1][k] <= ge[k] ? PW'(cur[k] - den) : cur[k][PW-1:0];
               dlow_ff[j+1][k] <= dlow_ff[j][k] << 1;
               dq_ff[j+1][k]   <= {dq_ff[j][k][CW-2:0], ge[k]};
            end
         end
      end
   end

   // Step from the start point towards the end point; zero on a miss
   always_comb begin
      logic [CW-1:0] qc;
      for (int k = 0; k < 3; k++) begin
         qc = (dq_ff[CW][k] > dc_ff[CW].geo.mag[k]) ? dc_ff[CW].geo.mag[k]
                                                     : dq_ff[CW][k];
         if (!dc_ff[CW].hit) begin
            point_in[k] = '0;
         end else if (dc_ff[CW].geo.neg[k]) begin
            point_in[k] = dc_ff[CW].geo.s[k] - qc;
         end else begin
            point_in[k] = dc_ff[CW].geo.s[k] + qc;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         rsp_valid_ff <= dv_ff[CW];
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         rsp_hit_ff <= dc_ff[CW].hit;
         for (int k = 0; k < 3; k++) begin
            point_ff[k] <= point_in[k];
         end
      end
   end

endmodule

/* dv/tb_segment_sphere_intersect_unit.sv */
// Testbench of the segment-sphere intersection unit: drives segment/sphere requests,
// predicts hit and point with a wide-integer model, and checks every result in order.
// Depends on ssi_pkg and segment_sphere_intersect_unit.
`timescale 1ns / 100ps

module tb_segment_sphere_intersect_unit;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int MLW = ssi_pkg::MIN_LEN_WIDTH;
   localparam int LATENCY = 3*CW + 15;
   localparam int STALL_LIMIT = 20000;
   localparam int N_RANDOM = 1750;
   localparam int N_TABLE = 14;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [255:0] wide_type;

   typedef struct {
      coord_type sx, sy, sz, ex, ey, ez, cx, cy, cz;
      logic [CW-2:0] rad;
   } seg_req_type;

   typedef struct packed {
      logic      hit;
      coord_type px, py, pz;
   } isect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_start_x = '0, req_start_y = '0, req_start_z = '0;
   coord_type req_end_x = '0, req_end_y = '0, req_end_z = '0;
   coord_type req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [CW-2:0] req_sphere_radius = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   coord_type rsp_point_x, rsp_point_y, rsp_point_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [MLW-1:0] csr_min_length_sq = '0;

   logic [MLW-1:0] floor_reg;
   isect_type expected_q[$];
   int     errors = 0;
   int     idle_cycles = 0;
   bit     quiet_rsp = 1'b0;

   segment_sphere_intersect_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_start_z(req_start_z),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_end_z(req_end_z),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_center_z(req_center_z), .req_sphere_radius(req_sphere_radius),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_min_length_sq(csr_min_length_sq)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Integer square root, floor, of a nonnegative wide value
   function automatic wide_type isqrt_floor(wide_type v);
      wide_type res, bitv, t;
      res = '0;
      bitv = wide_type'(1) <<< 254;
      while (bitv != 0 && bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         t = res + bitv;
         if (v >= t) begin
            v = v - t;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Predict hit and entry point of one segment against one sphere
   function automatic isect_type predict_isect(seg_req_type r, logic [MLW-1:0] floor_sq);
      isect_type o;
      wide_type  s[3], d[3], f[3], a, h, c, disc, num, mag, q, t;
      s[0] = r.sx; s[1] = r.sy; s[2] = r.sz;
      d[0] = wide_type'(r.ex) - s[0];
      d[1] = wide_type'(r.ey) - s[1];
      d[2] = wide_type'(r.ez) - s[2];
      f[0] = s[0] - wide_type'(r.cx);
      f[1] = s[1] - wide_type'(r.cy);
      f[2] = s[2] - wide_type'(r.cz);
      a = '0; h = '0; c = '0;
      for (int k = 0; k < 3; k++) begin
         a += d[k] * d[k];
         h += d[k] * f[k];
         c += f[k] * f[k];
      end
      c -= wide_type'({1'b0, r.rad}) * wide_type'({1'b0, r.rad});
      o = '{1'b0, '0, '0, '0};
      if (a < (wide_type'({1'b0, floor_sq}) <<< FB) || a == 0) return o;
      disc = h * h - a * c;
      if (disc < 0 || c < 0 || h > 0) return o;
      if (a + h < 0) begin
         t = a + h + h + c;
         if (t > 0) return o;
      end
      num = -h - isqrt_floor(disc);
      o.hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
         mag = (d[k] < 0) ? -d[k] : d[k];
         q = (num * mag) / a;
         if (q > mag) q = mag;
         t = (d[k] < 0) ? s[k] - q : s[k] + q;
         case (k)
            0: o.px = t[CW-1:0];
            1: o.py = t[CW-1:0];
            default: o.pz = t[CW-1:0];
         endcase
      end
      return o;
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 32'h00A0_0000)) - 32'sh0050_0000);
         default: return coord_type'($signed($urandom_range(0, 32'h0140_0000)) - 32'sh00A0_0000);
      endcase
   endfunction

   function automatic coord_type jitter();
      return coord_type'($signed($urandom_range(0, 2**18)) - 2**17);
   endfunction

   // Mostly segments that are aimed through a nearby sphere, some pure noise
   function automatic seg_req_type rand_request();
      seg_req_type r;
      int mode;
      mode = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
      r.sx = rand_coord(mode); r.sy = rand_coord(mode); r.sz = rand_coord(mode);
      r.ex = rand_coord(mode); r.ey = rand_coord(mode); r.ez = rand_coord(mode);
      if (mode == 0) begin
         r.cx = rand_coord(0); r.cy = rand_coord(0); r.cz = rand_coord(0);
         r.rad = (CW-1)'($urandom);
      end else begin
         r.cx = coord_type'((r.sx + r.ex) >>> 1) + jitter();
         r.cy = coord_type'((r.sy + r.ey) >>> 1) + jitter();
         r.cz = coord_type'((r.sz + r.ez) >>> 1) + jitter();
         r.rad = (CW-1)'($urandom_range(0, 32'h0040_0000));
      end
      if ($urandom_range(0, 19) == 0) begin
         r.ex = r.sx; r.ey = r.sy; r.ez = r.sz;
      end
      return r;
   endfunction

   // No gaps over the tail of each phase
   function automatic bit take_break(int n);
      return (n >= 250) ? 1'b0 : ($urandom_range(0, 99) < 9);
   endfunction

   // Hold a request on the port until accepted, with random gaps before it
   task automatic send_request(seg_req_type r, int n);
      while (take_break(n)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_x <= r.sx; req_start_y <= r.sy; req_start_z <= r.sz;
      req_end_x <= r.ex; req_end_y <= r.ey; req_end_z <= r.ez;
      req_center_x <= r.cx; req_center_y <= r.cy; req_center_z <= r.cz;
      req_sphere_radius <= r.rad;
      expected_q.push_back(predict_isect(r, floor_reg));
      do @(posedge clock); while (!req_ready);
   endtask

   // Drain, then write the floor register while the unit is idle
   task automatic write_floor(logic [MLW-1:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_valid <= 1'b1;
      csr_min_length_sq <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      floor_reg = v;
   endtask

   // Result side: random stalls unless quiet_rsp is set, compare against the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= quiet_rsp ? 1'b1 : ($urandom_range(0, 99) >= 9);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result hit=%0b", $time, rsp_hit);
               errors++;
            end else begin
               isect_type e;
               e = expected_q.pop_front();
               if (rsp_hit !== e.hit || rsp_point_x !== e.px || rsp_point_y !== e.py ||
                   rsp_point_z !== e.pz) begin
                  $display("%0t: expected hit=%0b p=(%0d,%0d,%0d) actual hit=%0b p=(%0d,%0d,%0d)",
                           $time, e.hit, e.px, e.py, e.pz,
                           rsp_hit, rsp_point_x, rsp_point_y, rsp_point_z);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("segment_sphere_intersect_unit: mismatch");
         $finish;
      end
   end

   initial begin
      seg_req_type dir_tbl[N_TABLE];
      isect_type   res_tbl[N_TABLE];
      bit          typed[N_TABLE];
      isect_type   miss;
      localparam coord_type ONE = coord_type'(1 <<< FB);
      localparam coord_type MAXC = {1'b0, {(CW-1){1'b1}}};
      localparam coord_type MINC = {1'b1, {(CW-1){1'b0}}};
      miss = '{1'b0, '0, '0, '0};
      // Straight hit along x through a unit sphere at 5: enters at 4
      dir_tbl[0] = '{0, 0, 0, 10*ONE, 0, 0, 5*ONE, 0, 0, ONE};
      res_tbl[0] = '{1'b1, 4*ONE, 0, 0}; typed[0] = 1;
      // Zero-length segment
      dir_tbl[1] = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE};
      res_tbl[1] = miss; typed[1] = 1;
      // Start inside the sphere
      dir_tbl[2] = '{0, 0, 0, 10*ONE, 0, 0, 0, 0, 0, 3*ONE};
      res_tbl[2] = miss; typed[2] = 1;
      // Sphere beyond the end point
      dir_tbl[3] = '{0, 0, 0, ONE, 0, 0, 9*ONE, 0, 0, ONE};
      res_tbl[3] = miss; typed[3] = 1;
      // Sphere behind the start point
      dir_tbl[4] = '{0, 0, 0, ONE, 0, 0, -5*ONE, 0, 0, ONE};
      res_tbl[4] = miss; typed[4] = 1;
      // Line passes beside the sphere, negative discriminant
      dir_tbl[5] = '{0, 0, 0, 10*ONE, 0, 0, 5*ONE, 5*ONE, 0, ONE};
      res_tbl[5] = miss; typed[5] = 1;
      // Segment far too short for the reset floor
      dir_tbl[6] = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0};
      res_tbl[6] = miss; typed[6] = 1;
      // Touches at the end point exactly
      dir_tbl[7] = '{0, 0, 0, 4*ONE, 0, 0, 5*ONE, 0, 0, ONE};
      res_tbl[7] = '{1'b1, 4*ONE, 0, 0}; typed[7] = 1;
      // Extremes of every coordinate and radius
      dir_tbl[8] = '{MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, 0, 0, '1};
      typed[8] = 0;
      dir_tbl[9] = '{MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0, '1};
      typed[9] = 0;
      dir_tbl[10] = '{MINC, 0, MAXC, MAXC, 0, MINC, 0, 0, 0, 0};
      typed[10] = 0;
      dir_tbl[11] = '{-1, -1, -1, MINC, MAXC, 0, -ONE, ONE, -ONE, '1};
      typed[11] = 0;
      // Diagonal hits with negative direction components
      dir_tbl[12] = '{3*ONE, 3*ONE, 3*ONE, -3*ONE, -2*ONE, -ONE, 0, 0, 0, 2*ONE};
      typed[12] = 0;
      dir_tbl[13] = '{-7*ONE, 2*ONE, 0, 7*ONE, -ONE, ONE, ONE, 0, 0, 4*ONE};
      typed[13] = 0;

      floor_reg = ssi_pkg::MIN_LEN_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, walked once at the reset floor
      for (int i = 0; i < N_TABLE; i++) begin
         if (typed[i] && predict_isect(dir_tbl[i], floor_reg) != res_tbl[i]) begin
            $display("%0t: expected table row %0d to match prediction", $time, i);
            errors++;
         end
         send_request(dir_tbl[i], i);
         if (typed[i]) void'(expected_q.pop_back());
         if (typed[i]) expected_q.push_back(res_tbl[i]);
      end

      // Random phases under several floors, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_floor('0);
            1: write_floor('1);
            2: write_floor(MLW'($urandom_range(0, 4000)));
            3: write_floor(MLW'($urandom));
            default: write_floor(ssi_pkg::MIN_LEN_RESET);
         endcase
         // Result side never stalls through one whole phase
         quiet_rsp = (ph == 3);
         for (int n = 0; n < N_RANDOM / 5; n++) send_request(rand_request(), n);
      end
      req_valid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      quiet_rsp = 1'b1;
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("segment_sphere_intersect_unit: match");
      else
         $display("segment_sphere_intersect_unit: mismatch");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_front.sv
hw/rtl/ssi_queue.sv
hw/rtl/ssi_back.sv
hw/rtl/segment_sphere_intersect_unit.sv
dv/tb_segment_sphere_intersect_unit.sv
